[rtl/core/bcr_pkg.sv]
// Shared package for the BCD calendar RTC block: opcodes, calendar limits,
// reset image of the calendar block, controller/datapath structs and BCD helpers.
// No dependencies.
package bcr_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] BLK_CTRL = 2'd0;
	localparam logic [1:0] BLK_LCK1 = 2'd1;
	localparam logic [1:0] BLK_CAL  = 2'd2;

	localparam int unsigned NUM_BLOCKS = 4;

	localparam logic [7:0] SEC_LIMIT  = 8'd60;
	localparam logic [7:0] MIN_LIMIT  = 8'd60;
	localparam logic [7:0] HOUR_LIMIT = 8'd24;
	localparam logic [7:0] WDAY_LIMIT = 8'd7;
	localparam logic [7:0] MON_LIMIT  = 8'd13;
	localparam logic [7:0] YEAR_SPAN  = 8'd100;
	localparam logic [7:0] HOUR_FLAG  = 8'h80;
	localparam logic [7:0] HOUR_MASK  = 8'h7f;

	// bytes 16..23: 00:00:00 (hour flag set), day 1, Thursday, January, 1970
	localparam logic [63:0] CAL_RESET = 64'h1970_0104_0180_0000;

	typedef struct packed {
		logic accept;
		logic incr;
		logic encode;
	} cmd_t;

	typedef struct packed {
		logic tick_go;
	} status_t;

	function automatic logic [7:0] bcd_in(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
	endfunction

	// divide by ten through reciprocal 205/2048, exact for all 8-bit values
	function automatic logic [7:0] bcd_out(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  r;
		prod = {8'd0, v} * 16'd205;
		q    = prod[15:11];
		r    = v - ({3'd0, q} << 3) - ({3'd0, q} << 1);
		return {q[3:0], r[3:0]};
	endfunction

	function automatic logic [4:0] days_in(input logic [7:0] mon, input logic leap);
		logic [4:0] d;
		case (mon) inside
			8'd4, 8'd6, 8'd9, 8'd11: d = 5'd30;
			8'd2:                    d = leap ? 5'd29 : 5'd28;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/bcr_req_if.sv]
// Request channel of the BCD calendar RTC block: valid/ready plus item fields.
// No dependencies.
interface bcr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [1:0]  block_index;
	logic [63:0] write_data;

	modport source(output valid, output opcode, output block_index, output write_data,
		input ready);
	modport sink(input valid, input opcode, input block_index, input write_data,
		output ready);
endinterface

[rtl/core/bcr_rsp_if.sv]
// Response channel of the BCD calendar RTC block: valid/ready plus result fields.
// No dependencies.
interface bcr_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_data;
	logic        write_ignored;
	logic        clock_running;

	modport source(output valid, output read_data, output write_ignored,
		output clock_running, input ready);
	modport sink(input valid, input read_data, input write_ignored,
		input clock_running, output ready);
endinterface

[rtl/core/bcr_ctrl.sv]
// Controller for the BCD calendar RTC block: sequences accept, calendar
// increment/encode steps and the response transfer. Depends on bcr_pkg.
module bcr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bcr_pkg::status_t status,
	output bcr_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INC  = 2'd1;
	localparam logic [1:0] ST_ENC  = 2'd2;
	localparam logic [1:0] ST_RSP  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_RSP);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.incr   = (state_q == ST_INC);
	assign cmd.encode = (state_q == ST_ENC);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = status.tick_go ? ST_INC : ST_RSP;
			end
			ST_INC: state_d = ST_ENC;
			ST_ENC: state_d = ST_RSP;
			ST_RSP: begin
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[rtl/core/bcr_dpath.sv]
// Datapath for the BCD calendar RTC block: 4x64-bit register file, locks,
// run/stop flag and the three-step calendar advance. Depends on bcr_pkg.
module bcr_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  bcr_pkg::cmd_t    cmd,
	output bcr_pkg::status_t status,
	input  logic [1:0]       opcode,
	input  logic [1:0]       block_index,
	input  logic [63:0]      write_data,
	output logic [63:0]      read_data,
	output logic             write_ignored,
	output logic             clock_running
);

	logic [63:0] blocks_q [bcr_pkg::NUM_BLOCKS];
	logic [1:0]  locks_q;
	logic        stopped_q;
	logic [1:0]  blk_q;
	logic        ignored_q;

	logic        locked;
	logic        do_write;
	logic [63:0] cal;

	// decode step
	logic [7:0] d_sec, d_min, d_hour, d_day, d_wday, d_mon, d_ylo, d_ycen;
	logic       yl_ge, leap;
	logic [7:0] cen_adj;

	logic [7:0] sec_s1, min_s1, hour_s1, day_s1, wday_s1, mon_s1, ylo_s1, ycen_s1;
	logic [4:0] mlen_s1;

	// increment step
	logic [7:0] n_sec, n_min, n_hour, n_day, n_wday, n_mon, n_yl, n_ylo, n_ycen;
	logic       c_s, c_m, c_h, c_d, c_mo, yl_wrap;

	logic [7:0] sec_s2, min_s2, hour_s2, day_s2, wday_s2, mon_s2, ylo_s2, ycen_s2;

	logic [63:0] cal_enc;

	assign locked = ((block_index == bcr_pkg::BLK_LCK1) && locks_q[0]) ||
		((block_index == bcr_pkg::BLK_CAL) && locks_q[1]);
	assign do_write = cmd.accept && (opcode == bcr_pkg::OP_WRITE) && !locked;

	assign status.tick_go = (opcode == bcr_pkg::OP_TICK) && !stopped_q;

	assign read_data     = blocks_q[blk_q];
	assign write_ignored = ignored_q;
	assign clock_running = !stopped_q;

	assign cal = blocks_q[bcr_pkg::BLK_CAL];

	always_comb begin
		d_sec   = bcr_pkg::bcd_in(cal[7:0]);
		d_min   = bcr_pkg::bcd_in(cal[15:8]);
		d_hour  = bcr_pkg::bcd_in(cal[23:16] & bcr_pkg::HOUR_MASK);
		d_day   = bcr_pkg::bcd_in(cal[31:24]);
		d_wday  = bcr_pkg::bcd_in(cal[39:32]);
		d_mon   = bcr_pkg::bcd_in(cal[47:40]);
		d_ylo   = bcr_pkg::bcd_in(cal[55:48]);
		d_ycen  = bcr_pkg::bcd_in(cal[63:56]);
		// low part stays below 200, so the century carry is one bit
		yl_ge   = (d_ylo >= bcr_pkg::YEAR_SPAN);
		cen_adj = d_ycen + {7'd0, yl_ge};
		leap    = (d_ylo[1:0] == 2'd0) &&
			(((d_ylo != 8'd0) && (d_ylo != bcr_pkg::YEAR_SPAN)) || (cen_adj[1:0] == 2'd0));
	end

	always_comb begin
		c_s   = (sec_s1 + 8'd1) >= bcr_pkg::SEC_LIMIT;
		n_sec = c_s ? 8'd0 : sec_s1 + 8'd1;

		c_m   = c_s && ((min_s1 + 8'd1) >= bcr_pkg::MIN_LIMIT);
		n_min = !c_s ? min_s1 : (c_m ? 8'd0 : min_s1 + 8'd1);

		c_h    = c_m && ((hour_s1 + 8'd1) >= bcr_pkg::HOUR_LIMIT);
		n_hour = !c_m ? hour_s1 : (c_h ? 8'd0 : hour_s1 + 8'd1);

		n_wday = !c_h ? wday_s1 :
			(((wday_s1 + 8'd1) >= bcr_pkg::WDAY_LIMIT) ? 8'd0 : wday_s1 + 8'd1);

		c_d   = c_h && ((day_s1 + 8'd1) > {3'd0, mlen_s1});
		n_day = !c_h ? day_s1 : (c_d ? 8'd1 : day_s1 + 8'd1);

		c_mo  = c_d && ((mon_s1 + 8'd1) >= bcr_pkg::MON_LIMIT);
		n_mon = !c_d ? mon_s1 : (c_mo ? 8'd1 : mon_s1 + 8'd1);

		n_yl    = ylo_s1 + {7'd0, c_mo};
		yl_wrap = (n_yl >= bcr_pkg::YEAR_SPAN);
		n_ylo   = yl_wrap ? n_yl - bcr_pkg::YEAR_SPAN : n_yl;
		n_ycen  = ycen_s1 + {7'd0, yl_wrap};
	end

	assign cal_enc = {
		bcr_pkg::bcd_out(ycen_s2),
		bcr_pkg::bcd_out(ylo_s2),
		bcr_pkg::bcd_out(mon_s2),
		bcr_pkg::bcd_out(wday_s2),
		bcr_pkg::bcd_out(day_s2),
		bcr_pkg::bcd_out(hour_s2) | bcr_pkg::HOUR_FLAG,
		bcr_pkg::bcd_out(min_s2),
		bcr_pkg::bcd_out(sec_s2)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q[0] <= 64'd0;
			blocks_q[1] <= 64'd0;
			blocks_q[2] <= bcr_pkg::CAL_RESET;
			blocks_q[3] <= 64'd0;
			locks_q     <= 2'd0;
			stopped_q   <= 1'b0;
			blk_q       <= 2'd0;
			ignored_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				blk_q     <= block_index;
				ignored_q <= (opcode == bcr_pkg::OP_WRITE) && locked;
			end
			if (do_write) begin
				blocks_q[block_index] <= write_data;
				if (block_index == bcr_pkg::BLK_CTRL) begin
					locks_q   <= write_data[9:8];
					stopped_q <= write_data[2];
				end
			end
			if (cmd.encode)
				blocks_q[bcr_pkg::BLK_CAL] <= cal_enc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sec_s1  <= d_sec;
			min_s1  <= d_min;
			hour_s1 <= d_hour;
			day_s1  <= d_day;
			wday_s1 <= d_wday;
			mon_s1  <= d_mon;
			ylo_s1  <= d_ylo;
			ycen_s1 <= d_ycen;
			mlen_s1 <= bcr_pkg::days_in(d_mon, leap);
		end
		if (cmd.incr) begin
			sec_s2  <= n_sec;
			min_s2  <= n_min;
			hour_s2 <= n_hour;
			day_s2  <= n_day;
			wday_s2 <= n_wday;
			mon_s2  <= n_mon;
			ylo_s2  <= n_ylo;
			ycen_s2 <= n_ycen;
		end
	end

endmodule

[rtl/core/bcd_calendar_rtc_block_registers.sv]
// Top level of the BCD calendar RTC block: controller, datapath and channel glue.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if, bcr_ctrl, bcr_dpath.
//
// Usage:
//   req carries one item: opcode (read, write, one-second tick, no-op),
//   block_index and 64 bits of write data. rsp returns one result per item:
//   the addressed block after the operation, the write-ignored flag for a
//   write to a locked block, and whether the clock is running.
// Timing:
//   One item at a time. Read, write and no-op: response valid the cycle after
//   the transfer. A tick while running goes through decode, increment and
//   encode of the calendar block before its response is valid. req.ready is
//   high again the cycle after the response transfer, so a new item is taken
//   only once the previous response has been transferred.
// Reset:
//   arst_n clears locks, runs the clock and loads 1970-01-01 00:00:00 Thursday
//   into block 2; all other bytes are zero.
// Stall:
//   While rsp.ready is low the response holds and req.ready stays low.
module bcd_calendar_rtc_block_registers (
	input  logic      clk,
	input  logic      arst_n,
	bcr_req_if.sink   req,
	bcr_rsp_if.source rsp
);

	bcr_pkg::cmd_t    cmd;
	bcr_pkg::status_t status;

	bcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bcr_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.opcode        (req.opcode),
		.block_index   (req.block_index),
		.write_data    (req.write_data),
		.read_data     (rsp.read_data),
		.write_ignored (rsp.write_ignored),
		.clock_running (rsp.clock_running)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while a response is pending");

	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode != bcr_pkg::OP_TICK) |=> rsp.valid)
		else $error("non-tick response not presented next cycle");

	a_tick_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == bcr_pkg::OP_TICK && rsp.clock_running)
		|=> !rsp.valid ##1 !rsp.valid ##1 rsp.valid)
		else $error("running tick did not take the calendar steps");

	a_no_cal_change: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && $past(rsp.valid)) |-> $stable(rsp.read_data))
		else $error("register file changed while response pending");

endmodule

[sim/bcd_calendar_rtc_block_registers_tb.sv]
`timescale 1ns / 100ps
// Testbench for bcd_calendar_rtc_block_registers: register reads, writes, locks, clock stop
// and BCD calendar ticks, checked transfer by transfer against a calendar predictor.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if and the RTL top level.
module bcd_calendar_rtc_block_registers_tb;

	localparam logic [1:0] BLK_USER = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned REPORT_CAP = 60;

	typedef struct packed {
		logic [63:0] data;
		logic        ignored;
		logic        running;
	} rtc_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bcr_req_if req ();
	bcr_rsp_if rsp ();

	bcd_calendar_rtc_block_registers i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [7:0]  rtc_bytes [32];
	logic        rtc_stopped;
	logic [1:0]  rtc_locks;
	rtc_resp_t   pending_q [$];
	rtc_resp_t   expected_resp;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;

	always #5 clk = ~clk;

	function automatic int unsigned bcd_value(input logic [7:0] b);
		return {28'd0, b[7:4]} * 10 + {28'd0, b[3:0]};
	endfunction

	function automatic logic [7:0] bcd_byte(input int unsigned v);
		logic [3:0] tens;
		logic [3:0] units;
		tens = 4'((v / 10) % 16);
		units = 4'(v % 10);
		return {tens, units};
	endfunction

	function automatic int unsigned month_length(input int unsigned mon, input int unsigned year);
		case (mon)
		4, 6, 9, 11: return 30;
		2: return ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0))) ? 29 : 28;
		default: return 31;
		endcase
	endfunction

	function automatic void reset_rtc_model();
		foreach (rtc_bytes[i])
			rtc_bytes[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			rtc_bytes[16 + i] = bcr_pkg::CAL_RESET[8*i +: 8];
		rtc_stopped = 1'b0;
		rtc_locks = 2'b00;
	endfunction

	function automatic void advance_second();
		int unsigned sec, min, hour, day, wday, mon, year;
		sec = bcd_value(rtc_bytes[16]);
		min = bcd_value(rtc_bytes[17]);
		hour = bcd_value(rtc_bytes[18] & bcr_pkg::HOUR_MASK);
		day = bcd_value(rtc_bytes[19]);
		wday = bcd_value(rtc_bytes[20]);
		mon = bcd_value(rtc_bytes[21]);
		year = bcd_value(rtc_bytes[22]) + 100 * bcd_value(rtc_bytes[23]);
		sec++;
		if (sec >= bcr_pkg::SEC_LIMIT) begin
			sec = 0;
			min++;
			if (min >= bcr_pkg::MIN_LIMIT) begin
				min = 0;
				hour++;
				if (hour >= bcr_pkg::HOUR_LIMIT) begin
					hour = 0;
					wday++;
					if (wday >= bcr_pkg::WDAY_LIMIT)
						wday = 0;
					day++;
					if (day > month_length(mon, year)) begin
						day = 1;
						mon++;
						if (mon >= bcr_pkg::MON_LIMIT) begin
							mon = 1;
							year++;
						end
					end
				end
			end
		end
		rtc_bytes[16] = bcd_byte(sec);
		rtc_bytes[17] = bcd_byte(min);
		rtc_bytes[18] = bcd_byte(hour) | bcr_pkg::HOUR_FLAG;
		rtc_bytes[19] = bcd_byte(day);
		rtc_bytes[20] = bcd_byte(wday);
		rtc_bytes[21] = bcd_byte(mon);
		rtc_bytes[22] = bcd_byte(year % bcr_pkg::YEAR_SPAN);
		rtc_bytes[23] = bcd_byte(year / bcr_pkg::YEAR_SPAN);
	endfunction

	function automatic rtc_resp_t predict_rtc(input logic [1:0] opcode, input logic [1:0] blk,
		input logic [63:0] wdata);
		rtc_resp_t r;
		logic [4:0] base;
		logic locked;
		r = '0;
		base = {blk, 3'd0};
		locked = (blk == bcr_pkg::BLK_LCK1 && rtc_locks[0]) ||
			(blk == bcr_pkg::BLK_CAL && rtc_locks[1]);
		if (opcode == bcr_pkg::OP_WRITE) begin
			if (locked) begin
				r.ignored = 1'b1;
			end else begin
				for (int i = 0; i < 8; i++)
					rtc_bytes[base + i] = wdata[8*i +: 8];
				if (blk == bcr_pkg::BLK_CTRL) begin
					rtc_locks = rtc_bytes[1][1:0];
					rtc_stopped = rtc_bytes[0][2];
				end
			end
		end else if (opcode == bcr_pkg::OP_TICK && !rtc_stopped) begin
			advance_second();
		end
		for (int i = 0; i < 8; i++)
			r.data[8*i +: 8] = rtc_bytes[base + i];
		r.running = !rtc_stopped;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < REPORT_CAP)
			$display("%0t: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// called at a falling edge; returns at the falling edge after the transfer with valid still up
	task automatic send_item(input logic [1:0] opcode, input logic [1:0] blk,
		input logic [63:0] wdata);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= opcode;
		req.block_index <= blk;
		req.write_data <= wdata;
		do @(posedge clk); while (!req.ready);
		pending_q.push_back(predict_rtc(opcode, blk, wdata));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending_q.size() != 0);
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] near_rollover();
		int unsigned mon, year;
		logic [7:0] f [8];
		year = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 99)
			: $urandom_range(0, 9999);
		mon = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 12);
		f[0] = ($urandom_range(0, 3) != 0) ? 8'h59 : bcd_byte($urandom_range(0, 59));
		f[1] = ($urandom_range(0, 3) != 0) ? 8'h59 : bcd_byte($urandom_range(0, 59));
		f[2] = bcd_byte(($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23))
			| (($urandom_range(0, 1) != 0) ? bcr_pkg::HOUR_FLAG : 8'h00);
		f[3] = bcd_byte(($urandom_range(0, 2) != 0) ? month_length(mon, year)
			: $urandom_range(1, 31));
		f[4] = bcd_byte($urandom_range(0, 6));
		f[5] = bcd_byte(mon);
		f[6] = bcd_byte(year % 100);
		f[7] = bcd_byte(year / 100);
		if ($urandom_range(0, 5) == 0)
			f[$urandom_range(0, 7)] = 8'($urandom());
		return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
	endfunction

	task automatic test_reset_image();
		send_item(bcr_pkg::OP_READ, bcr_pkg::BLK_CTRL, '0);
		send_item(bcr_pkg::OP_READ, bcr_pkg::BLK_LCK1, '1);
		send_item(bcr_pkg::OP_READ, bcr_pkg::BLK_CAL, '0);
		send_item(bcr_pkg::OP_READ, BLK_USER, '0);
		send_item(bcr_pkg::OP_NOP, bcr_pkg::BLK_CAL, '1);
	endtask

	task automatic test_block_writes();
		send_item(bcr_pkg::OP_WRITE, BLK_USER, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_LCK1, 64'hA55A_0FF0_1234_5678);
	endtask

	task automatic test_locks();
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CTRL, 64'h0000_0000_0000_0300);
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_LCK1, 64'h0);
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CTRL, 64'h0);
	endtask

	task automatic test_clock_stop();
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CTRL, 64'h0000_0000_0000_0004);
		send_item(bcr_pkg::OP_TICK, bcr_pkg::BLK_CAL, '0);
		send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CTRL, 64'h0);
	endtask

	task automatic test_rollovers();
		logic [63:0] dates [5];
		// year end, leap by 400, no leap by 100, month out of range, bad nibbles with century wrap
		dates = '{64'h1999_1205_3123_5959, 64'h2000_0201_2823_5959, 64'h1900_0203_28A3_5959,
			64'h2024_1506_3123_5959, 64'h9999_12FF_3123_5F5A};
		foreach (dates[i]) begin
			send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CAL, dates[i]);
			send_item(bcr_pkg::OP_TICK, bcr_pkg::BLK_CAL, random_word());
		end
	endtask

	task automatic test_random_mix(input int unsigned count);
		repeat (count)
			send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), random_word());
	endtask

	task automatic test_calendar_runs(input int unsigned runs);
		logic [63:0] ctrl;
		for (int r = 0; r < runs; r++) begin
			ctrl = random_word();
			if ($urandom_range(0, 7) != 0)
				ctrl[2] = 1'b0;
			if ($urandom_range(0, 3) != 0)
				ctrl[9:8] = 2'b00;
			send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CTRL, ctrl);
			send_item(bcr_pkg::OP_WRITE, bcr_pkg::BLK_CAL, near_rollover());
			repeat ($urandom_range(1, 5))
				send_item(bcr_pkg::OP_TICK,
					($urandom_range(0, 3) != 0) ? bcr_pkg::BLK_CAL : 2'($urandom_range(0, 3)),
					random_word());
			if ($urandom_range(0, 2) == 0)
				send_item(bcr_pkg::OP_READ, bcr_pkg::BLK_CAL, random_word());
			// hold the request side until every response is back
			if (r % 10 == 9)
				wait_idle();
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		quiet = 1'b1;
		test_random_mix(count);
	endtask

	always begin
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		rsp.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected transfer", rsp.read_data, '0);
			end else begin
				expected_resp = pending_q.pop_front();
				if (rsp.read_data !== expected_resp.data)
					report_mismatch("read_data", rsp.read_data, expected_resp.data);
				if (rsp.write_ignored !== expected_resp.ignored)
					report_mismatch("write_ignored", {63'd0, rsp.write_ignored},
						{63'd0, expected_resp.ignored});
				if (rsp.clock_running !== expected_resp.running)
					report_mismatch("clock_running", {63'd0, rsp.clock_running},
						{63'd0, expected_resp.running});
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.opcode = bcr_pkg::OP_READ;
		req.block_index = bcr_pkg::BLK_CTRL;
		req.write_data = '0;
		rsp.ready = 1'b0;
		reset_rtc_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_image();
		test_block_writes();
		test_locks();
		test_clock_stop();
		test_rollovers();
		test_random_mix(140);
		test_calendar_runs(45);
		test_back_to_back(50);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
